FILE: src/radar_frame_stream_parser_unit_macros.svh
// Assertion helpers used by the checker file.
`ifndef RADAR_FRAME_STREAM_PARSER_UNIT_MACROS_SVH
`define RADAR_FRAME_STREAM_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, off during reset.
`define RFSP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rfsp assertion failed");

// Next-cycle implication, off during reset.
`define RFSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rfsp assertion failed");

`endif

FILE: src/rfsp_pkg.sv
package rfsp_pkg;

  // Largest frame accepted, bytes, including header and data check.
  localparam int FRAME_MAX = 256;

  localparam logic [7:0] START_BYTE_RESET = 8'h01;

  // Header layout (byte positions within the frame).
  localparam logic [8:0] POS_START    = 9'd0;
  localparam logic [8:0] POS_ID_HI    = 9'd1;
  localparam logic [8:0] POS_ID_LO    = 9'd2;
  localparam logic [8:0] POS_LEN_HI   = 9'd3;
  localparam logic [8:0] POS_LEN_LO   = 9'd4;
  localparam logic [8:0] POS_TYPE_HI  = 9'd5;
  localparam logic [8:0] POS_TYPE_LO  = 9'd6;
  localparam logic [8:0] POS_HDR_CHK  = 9'd7;
  localparam logic [8:0] HDR_BYTES    = 9'd8;

  // Payload length above this makes the frame oversize.
  localparam logic [15:0] LEN_LIMIT = 16'(FRAME_MAX - 9);

  typedef enum logic [2:0] {
    STATUS_INCOMPLETE     = 3'd0,
    STATUS_OK             = 3'd1,
    STATUS_INVALID_LENGTH = 3'd2,
    STATUS_HDR_CHK_ERR    = 3'd3,
    STATUS_DATA_CHK_ERR   = 3'd4
  } status_t;

  typedef struct packed {
    status_t     status;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [15:0] hdr_id;
    logic [7:0]  pay_len;
    logic [15:0] msg_kind;
    logic [7:0]  header_check;
    logic [7:0]  data_check;
    logic [8:0]  frame_len;
  } result_t;

endpackage

FILE: src/rfsp_in_stage.sv
module rfsp_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       advance,
  output logic       s1_valid,
  output logic [7:0] s1_byte
);

  logic accept;

  // Held byte blocks the port only while it cannot move on.
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte <= rx_byte;
    end
  end

endmodule

FILE: src/rfsp_frame_core.sv
module rfsp_frame_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_wdata,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  output rfsp_pkg::result_t result
);
  import rfsp_pkg::*;

  logic [7:0]  start_byte;
  logic [8:0]  byte_position, byte_position_next;
  logic [8:0]  frame_length_expected, frame_length_expected_next;
  logic [15:0] id_word, id_word_next;
  logic [15:0] length_word, length_word_next;
  logic [15:0] type_word, type_word_next;
  logic [7:0]  header_xor, header_xor_next;
  logic [7:0]  header_check_received, header_check_received_next;
  logic [7:0]  data_xor, data_xor_next;

  logic [8:0] pos_inc;
  logic [8:0] pay_offset;
  logic [8:0] frame_len_calc;

  assign pos_inc        = byte_position + 9'd1;
  assign pay_offset     = byte_position - HDR_BYTES;
  assign frame_len_calc = HDR_BYTES + length_word[8:0] + 9'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= START_BYTE_RESET;
    end else if (cfg_we) begin
      start_byte <= cfg_wdata;
    end
  end

  always_comb begin
    byte_position_next         = byte_position;
    frame_length_expected_next = frame_length_expected;
    id_word_next               = id_word;
    length_word_next           = length_word;
    type_word_next             = type_word;
    header_xor_next            = header_xor;
    header_check_received_next = header_check_received;
    data_xor_next              = data_xor;
    result                     = '0;

    if (step && !(byte_position == POS_START && rx_byte != start_byte)) begin
      byte_position_next = pos_inc;
      if (byte_position < POS_HDR_CHK) begin
        header_xor_next = header_xor ^ rx_byte;
      end
      case (byte_position)
        POS_ID_HI, POS_ID_LO:     id_word_next     = {id_word[7:0], rx_byte};
        POS_LEN_HI, POS_LEN_LO:   length_word_next = {length_word[7:0], rx_byte};
        POS_TYPE_HI, POS_TYPE_LO: type_word_next   = {type_word[7:0], rx_byte};
        POS_HDR_CHK:              header_check_received_next = rx_byte;
        default: ;
      endcase

      if (byte_position == POS_TYPE_LO && length_word > LEN_LIMIT) begin
        // oversize: drop the frame and hunt again
        result.status              = STATUS_INVALID_LENGTH;
        byte_position_next         = '0;
        frame_length_expected_next = '0;
        id_word_next               = '0;
        length_word_next           = '0;
        type_word_next             = '0;
        header_xor_next            = '0;
        header_check_received_next = '0;
        data_xor_next              = '0;
      end else begin
        if (byte_position == POS_TYPE_LO) begin
          frame_length_expected_next = frame_len_calc;
        end
        if (byte_position >= HDR_BYTES && frame_length_expected != '0 &&
            pos_inc < frame_length_expected) begin
          data_xor_next        = data_xor ^ rx_byte;
          result.payload_valid = 1'b1;
          result.payload_byte  = rx_byte;
          result.payload_index = pay_offset[7:0];
        end
        if (frame_length_expected != '0 && pos_inc >= frame_length_expected) begin
          // last byte is the data check
          if (~header_xor != header_check_received) begin
            result.status = STATUS_HDR_CHK_ERR;
          end else if (~data_xor != rx_byte) begin
            result.status = STATUS_DATA_CHK_ERR;
          end else begin
            result.status       = STATUS_OK;
            result.hdr_id       = id_word;
            result.pay_len      = length_word[7:0];
            result.msg_kind     = type_word;
            result.header_check = header_check_received;
            result.data_check   = rx_byte;
            result.frame_len    = frame_length_expected;
          end
          byte_position_next         = '0;
          frame_length_expected_next = '0;
          id_word_next               = '0;
          length_word_next           = '0;
          type_word_next             = '0;
          header_xor_next            = '0;
          header_check_received_next = '0;
          data_xor_next              = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position         <= '0;
      frame_length_expected <= '0;
      id_word               <= '0;
      length_word           <= '0;
      type_word             <= '0;
      header_xor            <= '0;
      header_check_received <= '0;
      data_xor              <= '0;
    end else begin
      byte_position         <= byte_position_next;
      frame_length_expected <= frame_length_expected_next;
      id_word               <= id_word_next;
      length_word           <= length_word_next;
      type_word             <= type_word_next;
      header_xor            <= header_xor_next;
      header_check_received <= header_check_received_next;
      data_xor              <= data_xor_next;
    end
  end

endmodule

FILE: src/rfsp_out_stage.sv
module rfsp_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  rfsp_pkg::result_t result,
  input  logic              out_stall,
  output logic              out_valid,
  output rfsp_pkg::result_t held
);
  import rfsp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

FILE: src/radar_frame_stream_parser_unit.sv
// Path: a byte accepted into the input register is parsed into the result register
//   once that register is free or emptying, and its result is handed on when out_stall is low.
// Throughput: one byte per cycle while the result channel is not stalled.
// Reset (rst, synchronous, active high): parser back to start-byte hunt, all frame
//   state zero, start byte 0x01, both pipeline registers empty.
module radar_frame_stream_parser_unit (
  input  logic        clk,
  input  logic        rst,
  // config: start-of-frame byte
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  // byte input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  // result channel, one transfer per input byte
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic        payload_valid,
  output logic [7:0]  payload_byte,
  output logic [7:0]  payload_index,
  output logic [15:0] hdr_id,
  output logic [7:0]  pay_len,
  output logic [15:0] msg_kind,
  output logic [7:0]  header_check,
  output logic [7:0]  data_check,
  output logic [8:0]  frame_len
);
  import rfsp_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       advance;
  result_t    result;
  result_t    held;

  // The held byte is parsed once the result register is free or emptying
  // in this cycle; the parse state moves only on that step, so every byte
  // gets exactly one result transfer.
  assign advance = s1_valid && (!out_valid || !out_stall);

  rfsp_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_byte  (s1_byte)
  );

  // Frame parser: start hunt, header fields, XOR checks, verdict.
  rfsp_frame_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (advance),
    .rx_byte   (s1_byte),
    .result    (result)
  );

  rfsp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .result    (result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .held      (held)
  );

  assign status        = held.status;
  assign payload_valid = held.payload_valid;
  assign payload_byte  = held.payload_byte;
  assign payload_index = held.payload_index;
  assign hdr_id        = held.hdr_id;
  assign pay_len       = held.pay_len;
  assign msg_kind      = held.msg_kind;
  assign header_check  = held.header_check;
  assign data_check    = held.data_check;
  assign frame_len     = held.frame_len;

endmodule

FILE: src/rfsp_checker.sv
`include "radar_frame_stream_parser_unit_macros.svh"

module rfsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic        payload_valid,
  input logic [15:0] hdr_id,
  input logic [7:0]  pay_len,
  input logic [8:0]  frame_len
);
  import rfsp_pkg::*;

  // stalled result stays put
  `RFSP_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(status) && $stable(payload_valid))
  // payload bytes never carry a verdict
  `RFSP_ASSERT_IMPLY(a_pay_no_verdict, clk, rst, out_valid && payload_valid, status == STATUS_INCOMPLETE)
  // frame fields are zero unless the frame passed
  `RFSP_ASSERT_IMPLY(a_fields_zero, clk, rst, out_valid && status != STATUS_OK, hdr_id == 16'd0 && frame_len == 9'd0)
  // a good frame's length is header plus payload plus check byte
  `RFSP_ASSERT_IMPLY(a_len_match, clk, rst, out_valid && status == STATUS_OK, frame_len == {1'b0, pay_len} + 9'd9)

endmodule

bind radar_frame_stream_parser_unit rfsp_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .status        (status),
  .payload_valid (payload_valid),
  .hdr_id        (hdr_id),
  .pay_len       (pay_len),
  .frame_len     (frame_len)
);

FILE: verif/radar_frame_stream_parser_unit_test.sv
`timescale 1ns / 1ps

// Byte stream in, one verdict per byte out. Bytes are fed through the stall
// handshake with random gaps; results are compared against a cycle-free
// software copy of the parser that runs as each byte is taken.
module radar_frame_stream_parser_unit_test;
  import rfsp_pkg::*;

  // Kinds of traffic the generator can put on the link.
  typedef enum {
    SHAPE_GOOD,
    SHAPE_BAD_HDR,
    SHAPE_BAD_DATA,
    SHAPE_OVERSIZE,
    SHAPE_CUT
  } frame_shape_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  status;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic [7:0]  payload_index;
  logic [15:0] hdr_id;
  logic [7:0]  pay_len;
  logic [15:0] msg_kind;
  logic [7:0]  header_check;
  logic [7:0]  data_check;
  logic [8:0]  frame_len;

  // Parser state as the testbench tracks it.
  logic [7:0]  start_byte_cfg;
  logic [8:0]  pos_now;
  logic [8:0]  frame_len_due;   // zero until the type field is complete
  logic [15:0] id_acc;
  logic [15:0] len_acc;
  logic [15:0] type_acc;
  logic [7:0]  hdr_sum;
  logic [7:0]  hdr_chk_seen;
  logic [7:0]  data_sum;

  result_t     frame_results_due[$];   // verdicts owed by the block, oldest first
  logic [7:0]  frame_bytes[$];         // frame under construction for the link

  bit gaps_on  = 1'b1;
  bit stall_on = 1'b1;

  int bytes_sent;
  int results_seen;
  int mismatches;
  int ok_frames;
  int hdr_err_frames;
  int data_err_frames;
  int oversize_frames;
  int payload_seen;

  radar_frame_stream_parser_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .payload_valid(payload_valid),
    .payload_byte (payload_byte),
    .payload_index(payload_index),
    .hdr_id       (hdr_id),
    .pay_len      (pay_len),
    .msg_kind     (msg_kind),
    .header_check (header_check),
    .data_check   (data_check),
    .frame_len    (frame_len)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Parser prediction
  // ---------------------------------------------------------------------------

  function automatic void parser_to_idle();
    pos_now       = '0;
    frame_len_due = '0;
    id_acc        = '0;
    len_acc       = '0;
    type_acc      = '0;
    hdr_sum       = '0;
    hdr_chk_seen  = '0;
    data_sum      = '0;
  endfunction

  // Advance the tracked parser by one byte and return the verdict it owes.
  function automatic result_t frame_parser_step(input logic [7:0] b);
    result_t     r;
    logic [8:0]  at;
    logic [16:0] span;
    r  = '0;
    at = pos_now;
    // Hunting: anything but the start byte is dropped with an empty verdict.
    if (at == POS_START && b != start_byte_cfg)
      return r;
    pos_now = at + 9'd1;
    if (at < POS_HDR_CHK)
      hdr_sum ^= b;
    case (at)
      POS_ID_HI, POS_ID_LO:     id_acc   = {id_acc[7:0], b};
      POS_LEN_HI, POS_LEN_LO:   len_acc  = {len_acc[7:0], b};
      POS_TYPE_HI, POS_TYPE_LO: type_acc = {type_acc[7:0], b};
      POS_HDR_CHK:              hdr_chk_seen = b;
      default: ;
    endcase
    // Length is known once the type field is in; oversize aborts right there.
    if (pos_now == POS_HDR_CHK) begin
      span = 17'(HDR_BYTES) + 17'(len_acc) + 17'd1;
      if (span > FRAME_MAX) begin
        parser_to_idle();
        r.status = STATUS_INVALID_LENGTH;
        return r;
      end
      frame_len_due = span[8:0];
    end
    // Payload: after the header, short of the data check byte.
    if (at >= HDR_BYTES && frame_len_due != '0 && pos_now < frame_len_due) begin
      data_sum         ^= b;
      r.payload_valid  = 1'b1;
      r.payload_byte   = b;
      r.payload_index  = 8'(at - HDR_BYTES);
    end
    if (frame_len_due == '0 || pos_now < frame_len_due)
      return r;
    // Last byte of the frame: header check wins over data check.
    if (8'(~hdr_sum) != hdr_chk_seen) begin
      r.status = STATUS_HDR_CHK_ERR;
    end else if (8'(~data_sum) != b) begin
      r.status = STATUS_DATA_CHK_ERR;
    end else begin
      r.status       = STATUS_OK;
      r.hdr_id       = id_acc;
      r.pay_len      = len_acc[7:0];
      r.msg_kind     = type_acc;
      r.header_check = hdr_chk_seen;
      r.data_check   = b;
      r.frame_len    = frame_len_due;
    end
    parser_to_idle();
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Link side: frame construction and byte transfers
  // ---------------------------------------------------------------------------

  // Fills frame_bytes with one frame under the current start byte. Oversize
  // frames stop after the type field since the parser drops out there.
  function automatic void build_frame(input frame_shape_t shape, input logic [15:0] len,
                                      input logic [15:0] id, input logic [15:0] mtype);
    logic [7:0] sum;
    logic [7:0] pb;
    int         n;
    int         keep;
    frame_bytes.delete();
    frame_bytes.push_back(start_byte_cfg);
    frame_bytes.push_back(id[15:8]);
    frame_bytes.push_back(id[7:0]);
    frame_bytes.push_back(len[15:8]);
    frame_bytes.push_back(len[7:0]);
    frame_bytes.push_back(mtype[15:8]);
    frame_bytes.push_back(mtype[7:0]);
    sum = 8'h00;
    foreach (frame_bytes[i])
      sum ^= frame_bytes[i];
    if (shape == SHAPE_OVERSIZE)
      return;
    if (shape == SHAPE_BAD_HDR)
      sum ^= 8'($urandom_range(1, 255));
    frame_bytes.push_back(~sum);
    sum = 8'h00;
    for (n = 0; n < int'(len); n++) begin
      pb   = 8'($urandom);
      sum ^= pb;
      frame_bytes.push_back(pb);
    end
    if (shape == SHAPE_BAD_DATA)
      sum ^= 8'($urandom_range(1, 255));
    frame_bytes.push_back(~sum);
    // Truncated frame: whatever follows gets swallowed as the rest of it.
    if (shape == SHAPE_CUT) begin
      keep        = $urandom_range(1, frame_bytes.size() - 1);
      frame_bytes = frame_bytes[0:keep-1];
    end
  endfunction

  // One input transfer. Valid is left high so the next byte can follow
  // back to back; await_results drops it when the link goes quiet.
  task automatic send_byte(input logic [7:0] b);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(negedge clk);
    while (in_stall !== 1'b0)
      @(negedge clk);
    @(posedge clk);
    frame_results_due.push_back(frame_parser_step(b));
    bytes_sent++;
  endtask

  task automatic send_span(input int first, input int last);
    int n;
    for (n = first; n <= last; n++)
      send_byte(frame_bytes[n]);
  endtask

  // Quiet the link and hold until every owed verdict has been seen.
  task automatic await_results();
    in_valid <= 1'b0;
    while (frame_results_due.size() != 0)
      @(posedge clk);
  endtask

  // Start byte only changes with the pipeline empty.
  task automatic set_start_byte(input logic [7:0] v);
    await_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we         <= 1'b0;
    start_byte_cfg = v;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts and the comparison
  // ---------------------------------------------------------------------------

  initial begin : sink_stall
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on result %0d, %0s: expected 0x%0h, got 0x%0h",
                 results_seen, name, want, got);
    end
  endtask

  // Outputs only move at the rising edge, so the falling edge sees settled
  // values; a transfer sampled here completes at the next rising edge.
  always @(negedge clk) begin : result_check
    result_t want;
    result_t got;
    if (rst === 1'b0 && out_valid === 1'b1 && out_stall === 1'b0) begin
      got.status        = status_t'(status);
      got.payload_valid = payload_valid;
      got.payload_byte  = payload_byte;
      got.payload_index = payload_index;
      got.hdr_id        = hdr_id;
      got.pay_len       = pay_len;
      got.msg_kind      = msg_kind;
      got.header_check  = header_check;
      got.data_check    = data_check;
      got.frame_len     = frame_len;
      if (frame_results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with nothing owed (status %0d)",
                   results_seen, status);
      end else begin
        want = frame_results_due.pop_front();
        check_field("status",        want.status,        got.status);
        check_field("payload_valid", want.payload_valid, got.payload_valid);
        check_field("payload_byte",  want.payload_byte,  got.payload_byte);
        check_field("payload_index", want.payload_index, got.payload_index);
        check_field("hdr_id",        want.hdr_id,        got.hdr_id);
        check_field("pay_len",       want.pay_len,       got.pay_len);
        check_field("msg_kind",      want.msg_kind,      got.msg_kind);
        check_field("header_check",  want.header_check,  got.header_check);
        check_field("data_check",    want.data_check,    got.data_check);
        check_field("frame_len",     want.frame_len,     got.frame_len);
      end
      results_seen++;
      case (got.status)
        STATUS_OK:             ok_frames++;
        STATUS_HDR_CHK_ERR:    hdr_err_frames++;
        STATUS_DATA_CHK_ERR:   data_err_frames++;
        STATUS_INVALID_LENGTH: oversize_frames++;
        default: ;
      endcase
      if (got.payload_valid)
        payload_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Idle noise at both byte extremes, then a good, a bad-header and an oversize
  // frame, the first two with the id and type fields at their extremes.
  task automatic test_basic_frames();
    send_byte(8'h00);
    send_byte(8'hFF);
    build_frame(SHAPE_GOOD, 16'd1, 16'hFFFF, 16'h0000);
    send_span(0, frame_bytes.size() - 1);
    build_frame(SHAPE_BAD_HDR, 16'd0, 16'h0000, 16'hFFFF);
    send_span(0, frame_bytes.size() - 1);
    build_frame(SHAPE_OVERSIZE, 16'hFFFF, 16'h1234, 16'hABCD);
    send_span(0, frame_bytes.size() - 1);
    await_results();
  endtask

  // Largest legal payload, first oversize length, and an empty payload with
  // a bad data check.
  task automatic test_length_limits();
    build_frame(SHAPE_GOOD, 16'(FRAME_MAX - 9), 16'($urandom), 16'($urandom));
    send_span(0, frame_bytes.size() - 1);
    build_frame(SHAPE_OVERSIZE, 16'(FRAME_MAX - 8), 16'($urandom), 16'($urandom));
    send_span(0, frame_bytes.size() - 1);
    build_frame(SHAPE_BAD_DATA, 16'd0, 16'($urandom), 16'($urandom));
    send_span(0, frame_bytes.size() - 1);
    await_results();
  endtask

  // Start byte at both extremes, and a change that lands mid-frame: the
  // frame already under way must finish under the old start byte.
  task automatic test_start_byte_setting();
    set_start_byte(8'h00);
    send_byte(8'h5A);
    send_byte(8'hFF);
    build_frame(SHAPE_GOOD, 16'd2, 16'($urandom), 16'($urandom));
    send_span(0, frame_bytes.size() - 1);
    set_start_byte(8'hFF);
    send_byte(8'h00);
    build_frame(SHAPE_GOOD, 16'd0, 16'($urandom), 16'($urandom));
    send_span(0, frame_bytes.size() - 1);
    build_frame(SHAPE_GOOD, 16'd3, 16'($urandom), 16'($urandom));
    send_span(0, 3);
    set_start_byte(8'hA5);
    send_span(4, frame_bytes.size() - 1);
    send_byte(8'hFF);
    build_frame(SHAPE_GOOD, 16'd1, 16'($urandom), 16'($urandom));
    send_span(0, frame_bytes.size() - 1);
    await_results();
  endtask

  // One unit of random link traffic: mostly well-formed frames with random
  // content, some corrupted, truncated or oversize, and bursts of noise.
  task automatic send_random_unit();
    int           pick;
    int           n;
    logic [15:0]  len;
    frame_shape_t shape;
    pick = $urandom_range(0, 99);
    len  = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 60))
                                       : 16'($urandom_range(0, 12));
    if (pick >= 92) begin
      n = $urandom_range(1, 8);
      repeat (n) send_byte(8'($urandom));
    end else begin
      if (pick < 55)      shape = SHAPE_GOOD;
      else if (pick < 65) shape = SHAPE_BAD_HDR;
      else if (pick < 75) shape = SHAPE_BAD_DATA;
      else if (pick < 83) shape = SHAPE_OVERSIZE;
      else                shape = SHAPE_CUT;
      if (shape == SHAPE_OVERSIZE)
        len = 16'($urandom_range(FRAME_MAX - 8, 65535));
      build_frame(shape, len, 16'($urandom), 16'($urandom));
      send_span(0, frame_bytes.size() - 1);
    end
    // Now and then the link goes quiet until the block has caught up.
    if ($urandom_range(0, 19) == 0)
      await_results();
  endtask

  // Four phases, each under its own start byte, reset value and zero among them.
  task automatic test_random_traffic();
    logic [7:0] phase_sob[4];
    int         phase;
    int         goal;
    phase_sob = '{8'h01, 8'($urandom), 8'h00, 8'($urandom)};
    for (phase = 0; phase < 4; phase++) begin
      set_start_byte(phase_sob[phase]);
      goal = bytes_sent + 30;
      while (bytes_sent < goal)
        send_random_unit();
    end
    await_results();
  endtask

  // Closing stretch at full rate: no gaps, no stalls.
  task automatic test_full_rate();
    int goal;
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    goal     = bytes_sent + 40;
    while (bytes_sent < goal)
      send_random_unit();
    await_results();
  endtask

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------

  initial begin : main_seq
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = 8'h00;
    in_valid  = 1'b0;
    rx_byte   = 8'h00;
    start_byte_cfg = START_BYTE_RESET;
    parser_to_idle();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_basic_frames();
    test_length_limits();
    test_start_byte_setting();
    test_random_traffic();
    test_full_rate();

    // Two register stages in the block; a few spare edges catch strays.
    repeat (6) @(posedge clk);
    $display("Covered %0d bytes and %0d results, %0d of them payload bytes.",
             bytes_sent, results_seen, payload_seen);
    $display("Verdicts seen: %0d ok, %0d header check, %0d data check, %0d oversize.",
             ok_frames, hdr_err_frames, data_err_frames, oversize_frames);
    if (mismatches == 0 && frame_results_due.size() == 0) begin
      $display("** radar_frame_stream_parser_unit: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results never arrived",
               mismatches, frame_results_due.size());
      $display("** radar_frame_stream_parser_unit: FAILED **");
    end
    $finish;
  end

  // Well past the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("timeout with %0d results outstanding", frame_results_due.size());
    $display("** radar_frame_stream_parser_unit: FAILED **");
    $finish;
  end

endmodule
